/* src/sha_pkg.sv */
// SHA-256 package: round constants, initial hash values, sequencer state type.
// No dependencies.
`default_nettype none
package sha_pkg;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenOffset  = 56;
  localparam logic [7:0]  PadMarker  = 8'h80;

  // input transaction kinds
  localparam logic KindByte   = 1'b0;
  localparam logic KindFinish = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } seq_state_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    return k[i];
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h [8];
    h = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
          32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
    return h[i];
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction
endpackage
`default_nettype wire

/* src/sha_round.sv */
// One SHA-256 round plus message schedule step, shared across all 64 rounds.
// Depends on sha_pkg.
`default_nettype none
module sha_round (
  input  wire logic [31:0] st [8],
  input  wire logic [31:0] w [16],
  input  wire logic [5:0]  rnd,
  output logic [31:0]      st_next [8],
  output logic [31:0]      w_next [16]
);
  import sha_pkg::*;
  logic [31:0] t1, t2, s0, s1, wi;

  always_comb begin
    wi = w[0];
    t1 = st[7] + (ror(st[4], 6) ^ ror(st[4], 11) ^ ror(st[4], 25)) +
         ((st[4] & st[5]) ^ (~st[4] & st[6])) + round_k(rnd) + wi;
    t2 = (ror(st[0], 2) ^ ror(st[0], 13) ^ ror(st[0], 22)) +
         ((st[0] & st[1]) ^ (st[0] & st[2]) ^ (st[1] & st[2]));
    st_next[0] = t1 + t2;
    st_next[1] = st[0];
    st_next[2] = st[1];
    st_next[3] = st[2];
    st_next[4] = st[3] + t1;
    st_next[5] = st[4];
    st_next[6] = st[5];
    st_next[7] = st[6];
    // schedule window shifts by one; new word from w[t-16], w[t-15], w[t-7], w[t-2]
    s0 = ror(w[1], 7) ^ ror(w[1], 18) ^ (w[1] >> 3);
    s1 = ror(w[14], 17) ^ ror(w[14], 19) ^ (w[14] >> 10);
    for (int i = 0; i < 15; i++) w_next[i] = w[i+1];
    w_next[15] = w[0] + s0 + w[9] + s1;
  end
endmodule
`default_nettype wire

/* src/sha256_byte_stream_hasher_core.sv */
// SHA-256 byte stream hasher top level: buffer, sequencer, chaining state.
// Depends on sha_pkg and sha_round.
//
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | kind, byte_value
//  out     | out_valid | out_stall | digest_word, word_index, last_word
//
// A data byte is taken while idle; the 64th byte of a block then runs 64 rounds
// and one fold in the shared round unit. Finish runs one pad step, 64 rounds and
// one fold per block (one or two blocks), then 8 output transactions. No
// clearing pass after reset: rst is synchronous and clears control state.
// in_stall is high while busy; out_stall holds the current digest word.
`default_nettype none
module sha256_byte_stream_hasher_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        kind,
  input  wire logic [7:0]  byte_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);
  import sha_pkg::*;

  seq_state_t state, state_next;
  logic [31:0] w [16];
  logic [31:0] w_next [16];
  logic [31:0] h [8];
  logic [31:0] v [8];
  logic [31:0] v_next [8];
  logic [63:0] bit_count;
  logic [5:0]  fill_count;
  logic [5:0]  rnd;
  logic        final_blk;   // block under compression ends the message
  logic        second_blk;  // length must go in another block
  logic [2:0]  oidx;
  logic        in_acc, out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  sha_round u_round (.st(v), .w(w), .rnd(rnd), .st_next(v_next), .w_next(w_next));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_acc) begin
        if (kind == KindFinish) state_next = ST_PAD;
        else if (fill_count == 6'd63) state_next = ST_ROUND;
      end
      ST_PAD:   state_next = ST_ROUND;
      ST_ROUND: if (rnd == 6'd63) state_next = ST_FOLD;
      ST_FOLD: begin
        if (second_blk) state_next = ST_PAD;
        else if (final_blk) state_next = ST_EMIT;
        else state_next = ST_IDLE;
      end
      ST_EMIT:  if (out_acc && oidx == 3'd7) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = (state != ST_IDLE);
    out_valid   = (state == ST_EMIT);
    digest_word = h[oidx];
    word_index  = oidx;
    last_word   = (oidx == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) h[i] <= init_h(3'(i));
      bit_count  <= '0;
      fill_count <= '0;
      rnd        <= '0;
      final_blk  <= 1'b0;
      second_blk <= 1'b0;
      oidx       <= '0;
    end else begin
      unique case (state)
        ST_IDLE: if (in_acc) begin
          if (kind == KindByte) begin
            // byte lands big-endian in its word of the window
            for (int b = 0; b < 4; b++)
              if (fill_count[1:0] == 2'(b))
                w[fill_count[5:2]][31-8*b -: 8] <= byte_value;
            bit_count  <= bit_count + 64'd8;
            fill_count <= fill_count + 6'd1;
            final_blk  <= 1'b0;
            if (fill_count == 6'd63)
              for (int i = 0; i < 8; i++) v[i] <= h[i];
          end else begin
            // drop marker and clear the tail of the block
            for (int j = 0; j < BlockBytes; j++) begin
              if (6'(j) == fill_count) w[j/4][31-8*(j%4) -: 8] <= PadMarker;
              else if (6'(j) > fill_count) w[j/4][31-8*(j%4) -: 8] <= 8'h00;
            end
            second_blk <= (fill_count >= 6'(LenOffset));
            final_blk  <= 1'b1;
          end
        end
        ST_PAD: begin
          // second pass of a two-block finish starts from an all-zero block
          if (!second_blk) begin
            w[14] <= bit_count[63:32];
            w[15] <= bit_count[31:0];
          end
          for (int i = 0; i < 8; i++) v[i] <= h[i];
          rnd <= '0;
        end
        ST_ROUND: begin
          v   <= v_next;
          w   <= w_next;
          rnd <= rnd + 6'd1;
        end
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
          fill_count <= '0;
          if (second_blk) begin
            second_blk <= 1'b0;
            for (int i = 0; i < 16; i++) w[i] <= '0;
          end
        end
        ST_EMIT: if (out_acc) begin
          oidx <= oidx + 3'd1;
          if (oidx == 3'd7) begin
            for (int i = 0; i < 8; i++) h[i] <= init_h(3'(i));
            bit_count <= '0;
            final_blk <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_no_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) |-> !out_valid) else $error("output during rounds");
  a_round_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && rnd != 6'd63) |=> (state == ST_ROUND && rnd == $past(rnd) + 6'd1))
    else $error("round counter skipped");
  a_emit_order: assert property (@(posedge clk) disable iff (rst)
    (out_acc && oidx != 3'd7) |=> (out_valid && oidx == $past(oidx) + 3'd1))
    else $error("digest word order broken");
  a_reinit: assert property (@(posedge clk) disable iff (rst)
    (out_acc && last_word) |=> (bit_count == 64'd0 && fill_count == 6'd0))
    else $error("state not reinitialized after digest");
`endif
endmodule
`default_nettype wire
